// ===== rtl/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Control bytes and cell values.
  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0720;

  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_SETCUR = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_TAB,
    S_SCROLL,
    S_FILL,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_linear;
  } rsp_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: command engine over a cell memory holding character and attribute.
// One command word in, one response word out. After reset the block blanks the whole cell
// memory before it takes its first command. A tab writes one space at a time. A scroll is
// bound by the single write port of the cell memory: it copies every cell but the top row
// and then blanks the bottom row. Clear screen writes every cell once. A finished response
// sits in an output register; if that register is still held by a stall, the engine waits
// for it to free up.
module text_console_writer #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  tcw_pkg::cmd_t                 cmd,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output tcw_pkg::rsp_t                 rsp
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLS);

  // Cell memory.
  logic [15:0]   mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_q;

  tcw_pkg::state_t state, state_next;
  logic [tcw_pkg::COLOR_W-1:0] fg, bg;
  logic [RW-1:0]  cur_row, row_next;
  logic [CW-1:0]  cur_col, col_next;
  logic [AW-1:0]  ptr, ptr_next;
  logic [15:0]    resp_data, resp_data_next;
  tcw_pkg::func_t op_func, op_func_next;
  logic [7:0]     op_char, op_char_next;
  logic [RW-1:0]  op_row, op_row_next;
  logic [CW-1:0]  op_col, op_col_next;

  logic [7:0]     attr;
  logic [15:0]    blank;
  logic [RW-1:0]  sat_row;
  logic [CW-1:0]  sat_col;
  logic [AW-1:0]  rd_cell;
  logic [AW-1:0]  cur_addr;
  logic [CW-1:0]  col_inc;
  logic           slot_free;
  logic           do_newline;
  logic           finish;
  logic           load;
  logic [15:0]    fin_data;
  logic [15:0]    load_data;
  tcw_pkg::rsp_t  rsp_next;

  assign attr      = {bg, fg};
  assign blank     = {attr, tcw_pkg::CH_SPACE};
  assign sat_row   = (int'(cmd.row) > ROWS - 1) ? LAST_ROW : RW'(cmd.row);
  assign sat_col   = (int'(cmd.col) > COLS - 1) ? LAST_COL : CW'(cmd.col);
  assign rd_cell   = AW'(int'(sat_row) * COLS + int'(sat_col));
  assign cur_addr  = AW'(int'(cur_row) * COLS + int'(cur_col));
  assign col_inc   = cur_col + 1'b1;
  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FG_RESET;
      bg <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_FG: fg <= cfg_data;
        tcw_pkg::CFG_BG: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::S_INIT;
      cur_row   <= '0;
      cur_col   <= '0;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_row   <= row_next;
      cur_col   <= col_next;
      ptr       <= ptr_next;
      rsp_valid <= load ? 1'b1 : (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    resp_data <= resp_data_next;
    op_func   <= op_func_next;
    op_char   <= op_char_next;
    op_row    <= op_row_next;
    op_col    <= op_col_next;
    if (load) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next     = state;
    row_next       = cur_row;
    col_next       = cur_col;
    ptr_next       = ptr;
    resp_data_next = resp_data;
    op_func_next   = op_func;
    op_char_next   = op_char;
    op_row_next    = op_row;
    op_col_next    = op_col;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = blank;
    mem_raddr      = rd_cell;
    cmd_stall      = 1'b1;
    do_newline     = 1'b0;
    finish         = 1'b0;
    fin_data       = 16'h0000;
    load           = 1'b0;

    case (state)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = tcw_pkg::RESET_CELL;
        if (ptr == LAST_CELL) begin
          ptr_next   = '0;
          state_next = tcw_pkg::S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      tcw_pkg::S_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          op_func_next = cmd.func;
          op_char_next = cmd.char_code;
          op_row_next  = sat_row;
          op_col_next  = sat_col;
          // The read of a read-cell command is issued right here.
          state_next   = (cmd.func == tcw_pkg::FUNC_READ) ? tcw_pkg::S_READ : tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        case (op_func)
          tcw_pkg::FUNC_PUT: begin
            if (op_char == tcw_pkg::CH_NL) begin
              do_newline = 1'b1;
            end else if (op_char == tcw_pkg::CH_CR) begin
              col_next = '0;
              finish   = 1'b1;
            end else if (op_char == tcw_pkg::CH_TAB) begin
              state_next = tcw_pkg::S_TAB;
            end else if (op_char == tcw_pkg::CH_BS) begin
              if (cur_col != '0) begin
                col_next  = cur_col - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cur_addr - 1'b1;
              end
              finish = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {attr, op_char};
              if (cur_col == LAST_COL) begin
                do_newline = 1'b1;
              end else begin
                col_next = col_inc;
                finish   = 1'b1;
              end
            end
          end
          tcw_pkg::FUNC_CLEAR: begin
            ptr_next   = '0;
            row_next   = '0;
            col_next   = '0;
            state_next = tcw_pkg::S_FILL;
          end
          tcw_pkg::FUNC_SETCUR: begin
            row_next = op_row;
            col_next = op_col;
            finish   = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      tcw_pkg::S_TAB: begin
        // One space per cycle; stops on a tab stop or at the line wrap.
        mem_we = 1'b1;
        if (cur_col == LAST_COL) begin
          do_newline = 1'b1;
        end else begin
          col_next = col_inc;
          if (col_inc[2:0] == 3'd0) begin
            finish = 1'b1;
          end
        end
      end

      tcw_pkg::S_SCROLL: begin
        // Read the cell one row down, write it back in the next cycle into the row above.
        mem_raddr = ptr + ROW_STRIDE;
        if (ptr != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr - 1'b1;
          mem_wdata = mem_q;
        end
        if (ptr == SCROLL_END) begin
          state_next = tcw_pkg::S_FILL;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      tcw_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        if (ptr == LAST_CELL) begin
          ptr_next = '0;
          finish   = 1'b1;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      tcw_pkg::S_READ: begin
        fin_data = mem_q;
        finish   = 1'b1;
      end

      tcw_pkg::S_RESP: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase

    if (do_newline) begin
      col_next = '0;
      if (cur_row == LAST_ROW) begin
        ptr_next   = '0;
        state_next = tcw_pkg::S_SCROLL;
      end else begin
        row_next = cur_row + 1'b1;
        finish   = 1'b1;
      end
    end

    if (finish) begin
      resp_data_next = fin_data;
      if (slot_free) begin
        load       = 1'b1;
        state_next = tcw_pkg::S_IDLE;
      end else begin
        state_next = tcw_pkg::S_RESP;
      end
    end

    load_data              = finish ? fin_data : resp_data;
    rsp_next.cell_data     = load_data;
    rsp_next.cursor_row    = 5'(row_next);
    rsp_next.cursor_col    = 7'(col_next);
    rsp_next.cursor_linear = 11'(int'(row_next) * COLS + int'(col_next));
  end

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks of the text console writer, bound to its top level.
module tcw_checker #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input tcw_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed or dropped");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp.cursor_col) < COLS) && (ROWS > 32 || int'(rsp.cursor_row) < ROWS))
    else $error("cursor outside the screen");

  a_cursor_linear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (ROWS <= 32) |->
      rsp.cursor_linear == 11'(int'(rsp.cursor_row) * COLS + int'(rsp.cursor_col)))
    else $error("linear cursor does not match row and column");

  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> cmd_stall && !rsp_valid)
    else $error("commands taken during the clearing pass after reset");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd_stall))
    else $error("response appeared without a command in progress");

endmodule

bind text_console_writer tcw_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/console_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the console's response words.
`timescale 1ns / 1ps
package console_scoreboard_pkg;

  localparam int NROWS  = tcw_pkg::ROWS_DEF;
  localparam int NCOLS  = tcw_pkg::COLS_DEF;
  localparam int NCELLS = NROWS * NCOLS;

  class console_scoreboard;
    logic [15:0] cells [NCELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [tcw_pkg::COLOR_W-1:0] fg_color;
    logic [tcw_pkg::COLOR_W-1:0] bg_color;
    tcw_pkg::rsp_t expected_q [$];
    int errors;

    function new();
      foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      fg_color = tcw_pkg::FG_RESET;
      bg_color = tcw_pkg::BG_RESET;
      errors = 0;
    endfunction

    function void set_color(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                            logic [tcw_pkg::COLOR_W-1:0] value);
      if (idx == tcw_pkg::CFG_FG) begin
        fg_color = value;
      end else begin
        bg_color = value;
      end
    endfunction

    function logic [15:0] cell_word(logic [7:0] ch);
      return {bg_color, fg_color, ch};
    endfunction

    function void scroll_up();
      for (int i = 0; i < NCELLS - NCOLS; i++) cells[i] = cells[i + NCOLS];
      for (int i = NCELLS - NCOLS; i < NCELLS; i++) cells[i] = cell_word(tcw_pkg::CH_SPACE);
      cur_row = NROWS - 1;
    endfunction

    function void advance_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= NROWS) scroll_up();
    endfunction

    // Returns 1 when the write ran off the end of the line.
    function bit write_char(logic [7:0] ch);
      cells[cur_row * NCOLS + cur_col] = cell_word(ch);
      cur_col++;
      if (cur_col >= NCOLS) begin
        advance_row();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void put_char(logic [7:0] ch);
      int unsigned target;
      if (ch == tcw_pkg::CH_NL) begin
        advance_row();
      end else if (ch == tcw_pkg::CH_CR) begin
        cur_col = 0;
      end else if (ch == tcw_pkg::CH_TAB) begin
        // A tab stops at the next tab stop or at the line wrap, whichever comes first.
        target = (cur_col + 8) & ~32'd7;
        while (cur_col < target) begin
          if (write_char(tcw_pkg::CH_SPACE)) break;
        end
      end else if (ch == tcw_pkg::CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
          cells[cur_row * NCOLS + cur_col] = cell_word(tcw_pkg::CH_SPACE);
        end
      end else begin
        void'(write_char(ch));
      end
    endfunction

    function void note_cmd(tcw_pkg::cmd_t c);
      int unsigned r;
      int unsigned k;
      logic [15:0] data;
      tcw_pkg::rsp_t e;
      r = (c.row > NROWS - 1) ? NROWS - 1 : c.row;
      k = (c.col > NCOLS - 1) ? NCOLS - 1 : c.col;
      data = '0;
      case (c.func)
        tcw_pkg::FUNC_PUT: begin
          put_char(c.char_code);
        end
        tcw_pkg::FUNC_CLEAR: begin
          foreach (cells[i]) cells[i] = cell_word(tcw_pkg::CH_SPACE);
          cur_row = 0;
          cur_col = 0;
        end
        tcw_pkg::FUNC_SETCUR: begin
          cur_row = r;
          cur_col = k;
        end
        tcw_pkg::FUNC_READ: begin
          data = cells[r * NCOLS + k];
        end
        default: ;
      endcase
      e.cell_data     = data;
      e.cursor_row    = cur_row[4:0];
      e.cursor_col    = cur_col[6:0];
      e.cursor_linear = 11'(cur_row * NCOLS + cur_col);
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_rsp(tcw_pkg::rsp_t got);
      tcw_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: response word with none expected: %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("cell_data", e.cell_data, got.cell_data);
      compare_field("cursor_row", e.cursor_row, got.cursor_row);
      compare_field("cursor_col", e.cursor_col, got.cursor_col);
      compare_field("cursor_linear", e.cursor_linear, got.cursor_linear);
    endfunction
  endclass

endpackage

// ===== tb/text_console_writer_tb.sv =====
// Testbench top for the text console writer: directed and random command words.
`timescale 1ns / 1ps
module text_console_writer_tb;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcw_pkg::COLOR_W-1:0]   cfg_data = '0;
  logic                          cmd_valid = 1'b0;
  logic                          cmd_stall;
  tcw_pkg::cmd_t                 cmd = '0;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  tcw_pkg::rsp_t                 rsp;

  bit                                     no_gaps = 1'b0;
  int unsigned                            cycle_count = 0;
  console_scoreboard_pkg::console_scoreboard sb;

  text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_rsp(rsp);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic tcw_pkg::cmd_t make_cmd(tcw_pkg::func_t f, logic [7:0] ch, int r, int c);
    tcw_pkg::cmd_t w;
    w.func = f;
    w.char_code = ch;
    w.row = 5'(r);
    w.col = 7'(c);
    return w;
  endfunction

  function automatic tcw_pkg::cmd_t random_cmd();
    tcw_pkg::cmd_t w;
    int unsigned pick;
    w.char_code = 8'($urandom_range(0, 255));
    w.row = 5'($urandom_range(0, 31));
    w.col = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 199);
    if (pick == 0) begin
      w.func = tcw_pkg::FUNC_CLEAR;
    end else if (pick < 125) begin
      w.func = tcw_pkg::FUNC_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 4) w.char_code = tcw_pkg::CH_NL;
      else if (pick < 8) w.char_code = tcw_pkg::CH_CR;
      else if (pick < 14) w.char_code = tcw_pkg::CH_TAB;
      else if (pick < 20) w.char_code = tcw_pkg::CH_BS;
    end else if (pick < 155) begin
      w.func = tcw_pkg::FUNC_SETCUR;
    end else begin
      w.func = tcw_pkg::FUNC_READ;
      // Half the reads look at the cursor's row, where recent writes landed.
      if ($urandom_range(0, 1) == 1) w.row = 5'(sb.cur_row);
    end
    return w;
  endfunction

  task automatic send_cmd(input tcw_pkg::cmd_t w);
    while (!no_gaps && $urandom_range(0, 99) < 30) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall);
    sb.note_cmd(w);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_colors(input logic [tcw_pkg::COLOR_W-1:0] fg,
                              input logic [tcw_pkg::COLOR_W-1:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= tcw_pkg::CFG_FG;
    cfg_data <= fg;
    @(posedge clk);
    sb.set_color(tcw_pkg::CFG_FG, fg);
    cfg_index <= tcw_pkg::CFG_BG;
    cfg_data <= bg;
    @(posedge clk);
    sb.set_color(tcw_pkg::CFG_BG, bg);
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_cmd(make_cmd(tcw_pkg::FUNC_READ, 8'h00, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'h48, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'hFF, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'h00, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'h80, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_TAB, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BS, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_CR, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BS, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NL, 0, 0));
    // Out of range cursor saturates to the bottom right corner; the next put wraps and scrolls.
    send_cmd(make_cmd(tcw_pkg::FUNC_SETCUR, 8'h00, 31, 127));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'h5A, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_READ, 8'h00, 23, 79));
    send_cmd(make_cmd(tcw_pkg::FUNC_SETCUR, 8'h00, 24, 78));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_TAB, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_SETCUR, 8'h00, 24, 3));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NL, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_SETCUR, 8'h00, 10, 76));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_TAB, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_READ, 8'h00, 31, 127));
    send_cmd(make_cmd(tcw_pkg::FUNC_READ, 8'h00, 10, 77));
    send_cmd(make_cmd(tcw_pkg::FUNC_CLEAR, 8'h00, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_READ, 8'h00, 0, 0));
    send_cmd(make_cmd(tcw_pkg::FUNC_PUT, 8'h7F, 0, 0));

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: write_colors(4'hF, 4'hF);
          2: write_colors(4'h0, 4'h0);
          3: write_colors(4'hF, 4'h0);
          4: write_colors(4'h0, 4'hF);
          default: write_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        endcase
      end
      // One phase runs with both sides at full rate.
      no_gaps <= (phase == 3);
      repeat (250) send_cmd(random_cmd());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
